// ===== sv/rbm_pkg.sv =====
// Shared types and constants for the byte modular exponentiation block.
`default_nettype none

package rbm_pkg;

    localparam int MOD_WIDTH  = 16;
    localparam int CNT_W      = $clog2(MOD_WIDTH);
    localparam int NCELL      = MOD_WIDTH + 2;
    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = ((MOD_WIDTH + 7) / 8) * 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register addresses, decoded on the word-select bit of paddr
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WB,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } t_op;

    typedef enum logic [1:0] {
        SEL_T,
        SEL_D1,
        SEL_D2
    } t_sel;

    typedef struct packed {
        logic clear;
        logic step;
        logic mult_bit;
    } t_chain_ctl;

endpackage

`default_nettype wire

// ===== sv/rbm_cell.sv =====
// One bit slice of the interleaved modular multiplier chain.
`default_nettype none

module rbm_cell import rbm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_clear,
    input  wire logic i_step,
    input  wire t_sel i_sel,
    input  wire logic i_nb,
    input  wire logic i_a,
    input  wire logic i_m,
    input  wire logic i_m2,
    input  wire logic i_c,
    input  wire logic i_b1,
    input  wire logic i_b2,
    output logic      o_c,
    output logic      o_b1,
    output logic      o_b2,
    output logic      o_r
);

    logic r_bit;
    logic n_bit;
    logic t_bit;
    logic d1_bit;
    logic d2_bit;

    // doubled neighbor bit plus the addend bit
    assign t_bit = i_nb ^ i_a ^ i_c;
    assign o_c   = (i_nb & i_a) | (i_nb & i_c) | (i_a & i_c);

    // trial subtraction of m and of 2m
    assign d1_bit = t_bit ^ i_m ^ i_b1;
    assign o_b1   = (~t_bit & i_m) | (~t_bit & i_b1) | (i_m & i_b1);
    assign d2_bit = t_bit ^ i_m2 ^ i_b2;
    assign o_b2   = (~t_bit & i_m2) | (~t_bit & i_b2) | (i_m2 & i_b2);

    always_comb begin
        case (i_sel)
            SEL_D1:  n_bit = d1_bit;
            SEL_D2:  n_bit = d2_bit;
            default: n_bit = t_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_bit <= 1'b0;
        end else if (i_step) begin
            r_bit <= n_bit;
        end
    end

    assign o_r = r_bit;

endmodule

`default_nettype wire

// ===== sv/rbm_chain.sv =====
// Row of bit-slice cells forming r = (2r + bit*a) mod m each step.
`default_nettype none

module rbm_chain import rbm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire t_chain_ctl           i_ctl,
    input  wire logic [MOD_WIDTH-1:0] i_a,
    input  wire logic [MOD_WIDTH-1:0] i_mod,
    output logic      [MOD_WIDTH-1:0] o_res
);

    logic [NCELL-1:0] r_bits;
    logic [NCELL:0]   c;
    logic [NCELL:0]   b1;
    logic [NCELL:0]   b2;
    t_sel             sel;

    assign c[0]  = 1'b0;
    assign b1[0] = 1'b0;
    assign b2[0] = 1'b0;

    // t is below 3m, so take t-2m if it holds, else t-m, else t
    always_comb begin
        if (!b2[NCELL]) begin
            sel = SEL_D2;
        end else if (!b1[NCELL]) begin
            sel = SEL_D1;
        end else begin
            sel = SEL_T;
        end
    end

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        logic nb;
        logic a_bit;
        logic m_bit;
        logic m2_bit;

        if (j == 0) begin : g_lo
            assign nb     = 1'b0;
            assign m2_bit = 1'b0;
        end else begin : g_nb
            assign nb = r_bits[j-1];
            if (j <= MOD_WIDTH) begin : g_m2
                assign m2_bit = i_mod[j-1];
            end else begin : g_m2z
                assign m2_bit = 1'b0;
            end
        end

        if (j < MOD_WIDTH) begin : g_op
            assign a_bit = i_a[j] & i_ctl.mult_bit;
            assign m_bit = i_mod[j];
        end else begin : g_opz
            assign a_bit = 1'b0;
            assign m_bit = 1'b0;
        end

        rbm_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (i_ctl.clear),
            .i_step  (i_ctl.step),
            .i_sel   (sel),
            .i_nb    (nb),
            .i_a     (a_bit),
            .i_m     (m_bit),
            .i_m2    (m2_bit),
            .i_c     (c[j]),
            .i_b1    (b1[j]),
            .i_b2    (b2[j]),
            .o_c     (c[j+1]),
            .o_b1    (b1[j+1]),
            .o_b2    (b2[j+1]),
            .o_r     (r_bits[j])
        );
    end

    assign o_res = r_bits[MOD_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== sv/rbm_seq.sv =====
// Square-and-multiply sequencer driving the multiplier chain.
`default_nettype none

module rbm_seq import rbm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [BYTE_W-1:0]    i_in_byte,
    input  wire logic [MOD_WIDTH-1:0] i_mod,
    input  wire logic [MOD_WIDTH-1:0] i_exp,
    input  wire logic                 i_out_free,
    input  wire logic [MOD_WIDTH-1:0] i_res,
    output logic                      o_in_ready,
    output logic                      o_done,
    output logic      [MOD_WIDTH-1:0] o_result,
    output t_chain_ctl                o_ctl,
    output logic      [MOD_WIDTH-1:0] o_a
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MOD_WIDTH - 1);

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [MOD_WIDTH-1:0] r_base, n_base;
    logic [MOD_WIDTH-1:0] r_exp, n_exp;
    logic [MOD_WIDTH-1:0] r_a, n_a;
    logic [MOD_WIDTH-1:0] r_b, n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_REDUCE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_a    <= n_a;
        r_b    <= n_b;
    end

    always_comb begin
        logic [MOD_WIDTH-1:0] acc_new;
        logic [MOD_WIDTH-1:0] base_new;
        logic [MOD_WIDTH-1:0] e_new;

        n_state  = r_state;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_a      = r_a;
        n_b      = r_b;
        o_ctl    = '0;
        o_done   = 1'b0;
        acc_new  = r_acc;
        base_new = r_base;
        e_new    = r_exp;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_exp = i_exp;
                    if (i_mod < MOD_WIDTH'(2)) begin
                        // degenerate modulus: every residue is zero
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        // reduce the byte by multiplying it with one
                        n_acc       = MOD_WIDTH'(1);
                        n_a         = MOD_WIDTH'(1);
                        n_b         = MOD_WIDTH'(i_in_byte);
                        n_op        = OP_REDUCE;
                        n_cnt       = '0;
                        o_ctl.clear = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // feed multiplier bits from the top down
                o_ctl.step     = 1'b1;
                o_ctl.mult_bit = r_b[MOD_WIDTH-1];
                n_b            = r_b << 1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                case (r_op)
                    OP_REDUCE: begin
                        base_new = i_res;
                    end
                    OP_MUL: begin
                        acc_new  = i_res;
                        e_new[0] = 1'b0;
                    end
                    OP_SQR: begin
                        base_new = i_res;
                        e_new    = r_exp >> 1;
                    end
                    default: begin
                        base_new = r_base;
                    end
                endcase
                n_acc  = acc_new;
                n_base = base_new;
                n_exp  = e_new;
                if (e_new == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.clear = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_RUN;
                    if (e_new[0]) begin
                        n_op = OP_MUL;
                        n_a  = acc_new;
                        n_b  = base_new;
                    end else begin
                        n_op = OP_SQR;
                        n_a  = base_new;
                        n_b  = base_new;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_result   = r_acc;
    assign o_a        = r_a;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RUN || r_state == S_DONE))
        else $error("accepted word did not start work");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == LAST_STEP) |=> (r_state == S_WB))
        else $error("multiply ran past its last step");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_out_free) |=> (r_state == S_DONE && $stable(r_acc)))
        else $error("result changed while waiting for output slot");
`endif

endmodule

`default_nettype wire

// ===== sv/rsa_byte_modexp_top.sv =====
// Top level: config registers, sequencer, multiplier chain and output register.
//
//  channel   | dir | handshake                       | payload
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata[7:0] plaintext_byte
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata[15:0] ciphertext
//  apb       | in  | psel & penable & pwrite         | 0x0 modulus, 0x4 public_exponent
//
// Each modular multiply runs 16 steps through the cell chain, one per multiplier
// bit, then a writeback. An item costs 1 byte reduction plus one square per
// exponent bit above the lowest and one multiply per set bit (only the reduction
// for a zero exponent), plus an accept step and an output handoff.
// Reset is synchronous and clears the control state; a new byte is taken once the
// previous result has moved into the output register, even if it is not yet taken.
`default_nettype none

module rsa_byte_modexp_top import rbm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] plaintext_byte
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,   // [15:0] ciphertext
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_exp;
    logic                 r_m_valid;
    logic [MOD_WIDTH-1:0] r_m_data;
    logic                 cfg_wr;
    logic                 out_free;
    logic                 seq_done;
    logic [MOD_WIDTH-1:0] seq_result;
    logic [MOD_WIDTH-1:0] chain_res;
    logic [MOD_WIDTH-1:0] op_a;
    t_chain_ctl           ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(2);
            r_exp <= MOD_WIDTH'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MODULUS:  r_mod <= pwdata[MOD_WIDTH-1:0];
                REG_EXPONENT: r_exp <= pwdata[MOD_WIDTH-1:0];
                default:      r_mod <= r_mod;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_EXPONENT: prdata = APB_DATA_W'(r_exp);
            default:      prdata = APB_DATA_W'(r_mod);
        endcase
    end

    assign out_free = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_m_data <= seq_result;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_m_data);

    rbm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_byte  (i_s_axis_tdata),
        .i_mod      (r_mod),
        .i_exp      (r_exp),
        .i_out_free (out_free),
        .i_res      (chain_res),
        .o_in_ready (o_s_axis_tready),
        .o_done     (seq_done),
        .o_result   (seq_result),
        .o_ctl      (ctl),
        .o_a        (op_a)
    );

    rbm_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a   (op_a),
        .i_mod (r_mod),
        .o_res (chain_res)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> (!r_m_valid || i_m_axis_tready))
        else $error("result written over a word not yet taken");
`endif

endmodule

`default_nettype wire
